FILE: design/mtrand_pkg.sv
`timescale 1ns / 1ps

package mtrand_pkg;

	localparam int IDX_W = 10;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [31:0] word_t;

	localparam int STATE_WORDS  = 624;
	localparam int TWIST_OFFSET = 397;

	localparam idx_t LAST_WORD  = idx_t'(STATE_WORDS - 1);
	localparam idx_t WRAP_POINT = idx_t'(STATE_WORDS - TWIST_OFFSET);
	localparam idx_t FAR_STEP   = idx_t'(TWIST_OFFSET);
	localparam idx_t FULL_COUNT = idx_t'(STATE_WORDS);

	localparam word_t SEED_MULT    = 32'd1812433253;
	localparam word_t TWIST_MATRIX = 32'h9908b0df;
	localparam word_t TEMPER_B     = 32'h9d2c5680;
	localparam word_t TEMPER_C     = 32'hefc60000;

	// shared unit operations
	localparam logic [1:0] OP_SEED_MUL = 2'd0;
	localparam logic [1:0] OP_TWIST    = 2'd1;
	localparam logic [1:0] OP_TEMPER   = 2'd2;

	typedef struct packed {
		logic       en;
		logic [1:0] op;
	} alu_ctl_t;

endpackage

FILE: design/mtrand_ram.sv
`timescale 1ns / 1ps

// 624 x 32 state table, one write port, two registered read ports
module mtrand_ram (
	input  logic                 clk,
	input  logic                 we,
	input  mtrand_pkg::idx_t     waddr,
	input  mtrand_pkg::word_t    wdata,
	input  mtrand_pkg::idx_t     raddr_a,
	input  mtrand_pkg::idx_t     raddr_b,
	output mtrand_pkg::word_t    rdata_a,
	output mtrand_pkg::word_t    rdata_b
);

	mtrand_pkg::word_t mem_q [mtrand_pkg::STATE_WORDS];
	mtrand_pkg::word_t rdata_a_q;
	mtrand_pkg::word_t rdata_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a_q <= mem_q[raddr_a];
		rdata_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

FILE: design/mtrand_alu.sv
`timescale 1ns / 1ps

// shared unit: seed multiply, twist, temper; result registered
module mtrand_alu (
	input  logic                  clk,
	input  mtrand_pkg::alu_ctl_t  ctl,
	input  logic                  twist_variant,
	input  mtrand_pkg::word_t     opa,
	input  mtrand_pkg::word_t     opb,
	input  mtrand_pkg::word_t     opc,
	output mtrand_pkg::word_t     res
);

	mtrand_pkg::word_t res_q;
	mtrand_pkg::word_t res_d;
	mtrand_pkg::word_t mixed;
	mtrand_pkg::word_t t1;
	mtrand_pkg::word_t t2;
	mtrand_pkg::word_t t3;
	logic              sel;

	always_comb begin
		// twist: opa = far word, opb = u, opc = v
		mixed = {opb[31], opc[30:0]};
		sel   = twist_variant ? opc[0] : opb[0];
		// temper: opa = state word
		t1 = opa ^ (opa >> 11);
		t2 = t1 ^ ((t1 << 7) & mtrand_pkg::TEMPER_B);
		t3 = t2 ^ ((t2 << 15) & mtrand_pkg::TEMPER_C);
		unique case (ctl.op)
			mtrand_pkg::OP_SEED_MUL: begin
				res_d = mtrand_pkg::SEED_MULT * (opa ^ (opa >> 30));
			end
			mtrand_pkg::OP_TWIST: begin
				res_d = opa ^ (mixed >> 1) ^ (sel ? mtrand_pkg::TWIST_MATRIX : 32'd0);
			end
			mtrand_pkg::OP_TEMPER: begin
				res_d = t3 ^ (t3 >> 18);
			end
			default: begin
				res_d = opa;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

endmodule

FILE: design/mt19937_mt_rand_generator.sv
`timescale 1ns / 1ps

// MT19937 word generator, 31-bit results.
// Input channel (in_valid/in_ready): mode 0 seeds the generator with
// seed_value and returns nothing; mode 1 draws one number, returned on the
// output channel (out_valid/out_ready) as random_value.
// in_ready is high only while the sequencer is idle; one transaction is
// worked at a time through a single shared unit (multiply/twist/temper)
// and a 624-word state RAM with one write and two registered read ports.
// Seed: each word is filled by a multiply, then an add and write; a full
// regeneration of the table follows.
// Draw: read, temper and output states in turn; a new draw is taken only after
// the last has been loaded into the output register. Once 624 words have been
// used, the next draw first regenerates the table, each word twisted, then written.
// The result sits in an output register; a new transaction is taken while
// it waits, and a later draw holds before its output stage until the
// receiver takes the pending one.
// Reset (arst_n low) clears control, counters and twist_variant; the table
// holds no defined data until a seed is done.
// cfg_we writes twist_variant (0: low bit of u picks the matrix term,
// 1: low bit of v); write it only while the block is idle.
module mt19937_mt_rand_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [31:0] seed_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] random_value
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_FILL_MUL = 4'd1;
	localparam logic [3:0] ST_FILL_WR  = 4'd2;
	localparam logic [3:0] ST_RG_LOAD  = 4'd3;
	localparam logic [3:0] ST_RG_RD    = 4'd4;
	localparam logic [3:0] ST_RG_EX    = 4'd5;
	localparam logic [3:0] ST_RG_WB    = 4'd6;
	localparam logic [3:0] ST_DRAW_RD  = 4'd7;
	localparam logic [3:0] ST_DRAW_EX  = 4'd8;
	localparam logic [3:0] ST_DRAW_OUT = 4'd9;

	logic [3:0]           state_q;
	logic                 twist_variant_q;
	logic                 pend_draw_q;
	mtrand_pkg::idx_t     idx_q;
	mtrand_pkg::idx_t     widx_q;
	mtrand_pkg::idx_t     read_index_q;
	mtrand_pkg::idx_t     words_left_q;
	mtrand_pkg::word_t    prev_q;
	mtrand_pkg::word_t    u_q;
	logic                 out_valid_q;
	logic [30:0]          random_value_q;

	// RAM and shared unit hookup
	logic                 mem_we;
	mtrand_pkg::idx_t     mem_waddr;
	mtrand_pkg::word_t    mem_wdata;
	mtrand_pkg::idx_t     raddr_a;
	mtrand_pkg::idx_t     raddr_b;
	mtrand_pkg::word_t    rd_a;
	mtrand_pkg::word_t    rd_b;
	mtrand_pkg::alu_ctl_t alu_ctl;
	mtrand_pkg::word_t    alu_a;
	mtrand_pkg::word_t    alu_res;
	mtrand_pkg::word_t    fill_word;
	mtrand_pkg::idx_t     far_idx;
	mtrand_pkg::idx_t     nxt_idx;
	logic                 in_fire;
	logic                 out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign random_value = random_value_q;

	// seed recurrence: product from the shared unit plus word index
	assign fill_word = alu_res + {22'd0, idx_q};

	// neighbors of word idx_q during regeneration
	assign far_idx = (idx_q < mtrand_pkg::WRAP_POINT) ? (idx_q + mtrand_pkg::FAR_STEP)
	                                                  : (idx_q - mtrand_pkg::WRAP_POINT);
	assign nxt_idx = (idx_q == mtrand_pkg::LAST_WORD) ? '0 : (idx_q + 10'd1);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = fill_word;
		raddr_a   = far_idx;
		raddr_b   = nxt_idx;
		alu_ctl   = '{en: 1'b0, op: mtrand_pkg::OP_TWIST};
		alu_a     = rd_a;
		unique case (state_q)
			ST_IDLE: begin
				mem_we    = in_fire && !mode;
				mem_waddr = '0;
				mem_wdata = seed_value;
			end
			ST_FILL_MUL: begin
				alu_ctl = '{en: 1'b1, op: mtrand_pkg::OP_SEED_MUL};
				alu_a   = prev_q;
			end
			ST_FILL_WR: begin
				mem_we = 1'b1;
			end
			ST_RG_LOAD: begin
				raddr_b = '0;
			end
			ST_RG_RD: begin
			end
			ST_RG_EX: begin
				alu_ctl = '{en: 1'b1, op: mtrand_pkg::OP_TWIST};
			end
			ST_RG_WB: begin
				mem_we    = 1'b1;
				mem_waddr = widx_q;
				mem_wdata = alu_res;
			end
			ST_DRAW_RD: begin
				raddr_b = read_index_q;
			end
			ST_DRAW_EX: begin
				raddr_b = read_index_q;
				alu_ctl = '{en: 1'b1, op: mtrand_pkg::OP_TEMPER};
				alu_a   = rd_b;
			end
			ST_DRAW_OUT: begin
				raddr_b = read_index_q;
			end
			default: begin
			end
		endcase
	end

	mtrand_ram u_ram (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	mtrand_alu u_alu (
		.clk           (clk),
		.ctl           (alu_ctl),
		.twist_variant (twist_variant_q),
		.opa           (alu_a),
		.opb           (u_q),
		.opc           (rd_b),
		.res           (alu_res)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			prev_q <= seed_value;
		end else if (state_q == ST_FILL_WR) begin
			prev_q <= fill_word;
		end
		// u holds the pre-twist value of the word being regenerated
		if ((state_q == ST_RG_RD) || (state_q == ST_RG_EX)) begin
			u_q <= rd_b;
		end
		if ((state_q == ST_DRAW_OUT) && out_free) begin
			random_value_q <= alu_res[31:1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			twist_variant_q <= 1'b0;
			pend_draw_q     <= 1'b0;
			idx_q           <= '0;
			widx_q          <= '0;
			read_index_q    <= '0;
			words_left_q    <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				twist_variant_q <= cfg_wdata;
			end
			// output register: load a new draw, else drop once taken
			if ((state_q == ST_DRAW_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						pend_draw_q <= mode;
						if (!mode) begin
							idx_q   <= 10'd1;
							state_q <= ST_FILL_MUL;
						end else if (words_left_q == '0) begin
							idx_q   <= '0;
							state_q <= ST_RG_LOAD;
						end else begin
							state_q <= ST_DRAW_RD;
						end
					end
				end
				ST_FILL_MUL: begin
					state_q <= ST_FILL_WR;
				end
				ST_FILL_WR: begin
					if (idx_q == mtrand_pkg::LAST_WORD) begin
						idx_q   <= '0;
						state_q <= ST_RG_LOAD;
					end else begin
						idx_q   <= idx_q + 10'd1;
						state_q <= ST_FILL_MUL;
					end
				end
				ST_RG_LOAD: begin
					state_q <= ST_RG_RD;
				end
				ST_RG_RD: begin
					state_q <= ST_RG_EX;
				end
				ST_RG_EX: begin
					widx_q <= idx_q;
					if (idx_q != mtrand_pkg::LAST_WORD) begin
						idx_q <= idx_q + 10'd1;
					end
					state_q <= ST_RG_WB;
				end
				ST_RG_WB: begin
					// next word's reads go out while this one is written
					if (widx_q == mtrand_pkg::LAST_WORD) begin
						read_index_q <= '0;
						words_left_q <= mtrand_pkg::FULL_COUNT;
						state_q      <= pend_draw_q ? ST_DRAW_RD : ST_IDLE;
					end else begin
						state_q <= ST_RG_EX;
					end
				end
				ST_DRAW_RD: begin
					state_q <= ST_DRAW_EX;
				end
				ST_DRAW_EX: begin
					state_q <= ST_DRAW_OUT;
				end
				ST_DRAW_OUT: begin
					if (out_free) begin
						read_index_q <= read_index_q + 10'd1;
						words_left_q <= words_left_q - 10'd1;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
